// File: sv/pifu_pkg.sv
// Shared types, codes and character constants of the printf integer formatter.
package pifu_pkg;

    // Field widths
    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 7;

    // Digit store: 22 digits cover 64 bits in octal, 20 in decimal, 16 in hex
    localparam int NDIG = 22;
    localparam int DLW  = 5;

    // Register indexes of the configuration port
    localparam logic [CFG_IW-1:0] REG_CONVERSION = 3'd0;
    localparam logic [CFG_IW-1:0] REG_SIZE_MODE  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_WIDTH      = 3'd2;
    localparam logic [CFG_IW-1:0] REG_PRECISION  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_FLAGS      = 3'd4;

    // Conversion codes
    localparam logic [2:0] CONV_SDEC = 3'd0;
    localparam logic [2:0] CONV_UDEC = 3'd1;
    localparam logic [2:0] CONV_OCT  = 3'd2;
    localparam logic [2:0] CONV_XLO  = 3'd3;
    localparam logic [2:0] CONV_XUP  = 3'd4;

    // Size codes
    localparam logic [1:0] SIZE_INT   = 2'd0;
    localparam logic [1:0] SIZE_SHORT = 2'd1;

    // Flag bit positions
    localparam int FLAG_LEFT  = 0;
    localparam int FLAG_PLUS  = 1;
    localparam int FLAG_SPACE = 2;
    localparam int FLAG_ALT   = 3;
    localparam int FLAG_ZPAD  = 4;

    // ASCII characters
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } base_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_PLAN1,
        ST_PLAN2,
        ST_EMIT
    } state_t;

    // Control from the sequencer to the digit engine
    typedef struct packed {
        logic  load;
        logic  step;
        logic  norm;
        logic  emit;
        base_t base;
    } dig_ctrl_t;

    // Status from the digit engine
    typedef struct packed {
        logic [3:0]     top;
        logic [DLW-1:0] dl;
    } dig_stat_t;

    // Map one digit to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {4'd0, d};
        end
        else
        begin
            c = (upper ? CH_A_UP : CH_A_LO) + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// File: sv/pifu_if.sv
// Handshake interfaces of the formatter: argument, text and configuration channels.
interface pifu_arg_if;
    import pifu_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value_bits;
    modport source (output valid, output value_bits, input ready);
    modport sink (input valid, input value_bits, output ready);
endinterface

interface pifu_text_if;
    import pifu_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last_char;
    modport source (output valid, output out_char, output last_char, input ready);
    modport sink (input valid, input out_char, input last_char, output ready);
endinterface

interface pifu_cfg_if;
    import pifu_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/pifu_digits.sv
// Digit engine: bit-serial binary to digit conversion, normalization and digit shift-out.
module pifu_digits (
    input  logic                      clk,
    input  pifu_pkg::dig_ctrl_t       ctrl,
    input  logic [pifu_pkg::VALUE_W-1:0] mag,
    output pifu_pkg::dig_stat_t       stat
);
    import pifu_pkg::*;

    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic [3:0]         dig_reg [NDIG];
    logic [3:0]         dig_next [NDIG];
    logic [DLW-1:0]     dl_reg, dl_next;
    logic [3:0]         adj [NDIG];
    logic [3:0]         shifted [NDIG];
    logic [NDIG-1:0]    hi;
    logic [NDIG-1:0]    carry;

    // Per-digit slices: decimal add-3 adjust, then shift one bit in from below
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (ctrl.base == BASE_DEC && dig_reg[i] >= 4'd5)
            begin
                adj[i] = dig_reg[i] + 4'd3;
            end
            else
            begin
                adj[i] = dig_reg[i];
            end
            hi[i] = (ctrl.base == BASE_OCT) ? adj[i][2] : adj[i][3];
        end
        carry[0] = mag_reg[VALUE_W-1];
        for (int i = 1; i < NDIG; i++)
        begin
            carry[i] = hi[i-1];
        end
        for (int i = 0; i < NDIG; i++)
        begin
            if (ctrl.base == BASE_OCT)
            begin
                shifted[i] = {1'b0, adj[i][1:0], carry[i]};
            end
            else
            begin
                shifted[i] = {adj[i][2:0], carry[i]};
            end
        end
    end

    // Load, convert one bit, or shift the digits up by one place
    always_comb
    begin
        mag_next = mag_reg;
        dl_next  = dl_reg;
        for (int i = 0; i < NDIG; i++)
        begin
            dig_next[i] = dig_reg[i];
        end
        if (ctrl.load)
        begin
            mag_next = mag;
            dl_next  = DLW'(NDIG);
            for (int i = 0; i < NDIG; i++)
            begin
                dig_next[i] = 4'd0;
            end
        end
        else if (ctrl.step)
        begin
            mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
            for (int i = 0; i < NDIG; i++)
            begin
                dig_next[i] = shifted[i];
            end
        end
        else if (ctrl.norm || ctrl.emit)
        begin
            dig_next[0] = 4'd0;
            for (int i = 1; i < NDIG; i++)
            begin
                dig_next[i] = dig_reg[i-1];
            end
            if (ctrl.norm)
            begin
                dl_next = dl_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        dl_reg  <= dl_next;
        dig_reg <= dig_next;
    end

    assign stat.top = dig_reg[NDIG-1];
    assign stat.dl  = dl_reg;

endmodule

// File: sv/printf_integer_formatter_unit.sv
// Top level of the printf integer formatter (conversions d, u, o, x, X).
//
// Channels: arg takes one 64-bit raw argument per request; text returns the
// characters of the formatted field, one per request, with last_char set on
// the final one; cfg writes the five format registers by index and is always
// ready. Write cfg only while the block is idle.
// Timing: after an argument is taken, a bit-serial conversion of all 64 bits
// runs through the digit engine, then leading zero digits are dropped and
// the plan states PLAN1 and PLAN2 size the field. Characters then follow,
// one per cycle while text is ready. The next argument is taken once the
// last character sits in the output register.
// A field with no characters at all produces no text requests.
// Reset: registers take their reset values (conversion d, int size, width 0,
// no precision, no flags), the sequencer is idle and the output is empty.
// Stall: while text is not ready the character in the output register holds
// and the sequencer waits; no character is dropped.
module printf_integer_formatter_unit #(
    parameter int MAX_FIELD_CHARS = 62
) (
    input  logic         clk,
    input  logic         rst_n,
    pifu_arg_if.sink     arg,
    pifu_text_if.source  text,
    pifu_cfg_if.sink     cfg
);
    import pifu_pkg::*;

    localparam int CW = $clog2(MAX_FIELD_CHARS + 1);
    localparam int WW = ((CW > 6) ? CW : 6) + 2;

    state_t state_reg, state_next;

    // Configuration registers
    logic [2:0] conv_reg;
    logic [1:0] size_reg;
    logic [5:0] width_reg;
    logic [6:0] prec_reg;
    logic [4:0] flags_reg;

    // Item control
    logic [5:0] bit_cnt_reg, bit_cnt_next;
    logic       neg_reg, neg_next;
    logic       vzero_reg, vzero_next;

    // Field plan
    logic [DLW-1:0]    dl_eff_reg, dl_eff_next;
    logic [CW-1:0]     zl_reg, zl_next;
    logic              sign_on_reg, sign_on_next;
    logic [CHAR_W-1:0] sign_chr_reg, sign_chr_next;
    logic              plen_reg, plen_next;
    logic              uz_reg, uz_next;
    logic              left_reg, left_next;

    // Emit counters
    logic [CW-1:0]  lead_reg, lead_next;
    logic [1:0]     pre_reg, pre_next;
    logic [CW-1:0]  zero_reg, zero_next;
    logic [DLW-1:0] dig_cnt_reg, dig_cnt_next;
    logic [CW-1:0]  trail_reg, trail_next;
    logic [CW-1:0]  rem_reg, rem_next;

    // Output register
    logic              ovalid_reg;
    logic [CHAR_W-1:0] ochar_reg;
    logic              olast_reg;

    logic [2:0]         conv_eff;
    base_t              base;
    logic               upper;
    logic [VALUE_W-1:0] vmask;
    logic [VALUE_W-1:0] vmasked;
    logic               sbit;
    logic               neg_now;
    logic [VALUE_W-1:0] mag_now;
    dig_ctrl_t          dig_ctrl;
    dig_stat_t          dig_stat;
    logic               norm_more;
    logic               slot_free;
    logic               emit;
    logic               dig_sel;
    logic [CHAR_W-1:0]  ch;

    logic [WW-1:0] prec_w, prec_c, dle_w, zl_w, content, width_w, width_c, pad_w, total_w;
    logic          has_prec;
    logic          oct_fix;

    // Map the conversion code and pick the base
    always_comb
    begin
        case (conv_reg)
            CONV_SDEC, CONV_UDEC, CONV_OCT, CONV_XLO, CONV_XUP: conv_eff = conv_reg;
            default: conv_eff = CONV_UDEC;
        endcase
        case (conv_eff)
            CONV_OCT:           base = BASE_OCT;
            CONV_XLO, CONV_XUP: base = BASE_HEX;
            default:            base = BASE_DEC;
        endcase
        upper = (conv_eff == CONV_XUP);
    end

    // Cut the argument to size and take the magnitude
    always_comb
    begin
        case (size_reg)
            SIZE_SHORT:
            begin
                vmask = 64'h0000_0000_0000_FFFF;
                sbit  = arg.value_bits[15];
            end
            SIZE_INT:
            begin
                vmask = 64'h0000_0000_FFFF_FFFF;
                sbit  = arg.value_bits[31];
            end
            default:
            begin
                vmask = '1;
                sbit  = arg.value_bits[VALUE_W-1];
            end
        endcase
        vmasked = arg.value_bits & vmask;
        neg_now = (conv_eff == CONV_SDEC) && sbit;
        mag_now = neg_now ? ((~vmasked + 64'd1) & vmask) : vmasked;
    end

    pifu_digits u_digits (
        .clk  (clk),
        .ctrl (dig_ctrl),
        .mag  (mag_now),
        .stat (dig_stat)
    );

    assign norm_more = (dig_stat.top == 4'd0) && (dig_stat.dl > DLW'(1));
    assign slot_free = !ovalid_reg || text.ready;

    // Field plan: precision zeros, sign, prefix, then padding
    always_comb
    begin
        has_prec = !prec_reg[6];
        prec_w   = WW'(prec_reg[5:0]);
        prec_c   = (prec_w > WW'(MAX_FIELD_CHARS - 2)) ? WW'(MAX_FIELD_CHARS - 2) : prec_w;
        dle_w    = (has_prec && prec_w == '0 && vzero_reg) ? '0 : WW'(dig_stat.dl);
        zl_w     = (has_prec && prec_c > dle_w) ? prec_c - dle_w : '0;
        oct_fix  = flags_reg[FLAG_ALT] && (conv_eff == CONV_OCT) && (zl_w == '0)
                   && !((dle_w != '0) && vzero_reg);
        content  = WW'(sign_on_reg) + (plen_reg ? WW'(2) : WW'(0)) + WW'(zl_reg)
                   + WW'(dl_eff_reg);
        width_w  = WW'(width_reg);
        width_c  = (width_w > WW'(MAX_FIELD_CHARS)) ? WW'(MAX_FIELD_CHARS) : width_w;
        pad_w    = (width_c > content) ? width_c - content : '0;
        total_w  = (width_c > content) ? width_c : content;
    end

    // Pick the next character of the field
    always_comb
    begin
        ch      = CH_SPACE;
        dig_sel = 1'b0;
        if (lead_reg != '0)
        begin
            ch = CH_SPACE;
        end
        else if (sign_on_reg)
        begin
            ch = sign_chr_reg;
        end
        else if (pre_reg != 2'd0)
        begin
            ch = (pre_reg == 2'd2) ? CH_ZERO : (upper ? CH_X_UP : CH_X_LO);
        end
        else if (zero_reg != '0)
        begin
            ch = CH_ZERO;
        end
        else if (dig_cnt_reg != '0)
        begin
            ch      = digit_char(dig_stat.top, upper);
            dig_sel = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (arg.valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (bit_cnt_reg == 6'd63)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (!norm_more)
                begin
                    state_next = ST_PLAN1;
                end
            end
            ST_PLAN1:
            begin
                state_next = ST_PLAN2;
            end
            ST_PLAN2:
            begin
                state_next = (total_w == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free && rem_reg == CW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        arg.ready     = 1'b0;
        emit          = 1'b0;
        dig_ctrl.load = 1'b0;
        dig_ctrl.step = 1'b0;
        dig_ctrl.norm = 1'b0;
        dig_ctrl.emit = 1'b0;
        dig_ctrl.base = base;
        case (state_reg)
            ST_IDLE:
            begin
                arg.ready     = 1'b1;
                dig_ctrl.load = arg.valid;
            end
            ST_CONV:
            begin
                dig_ctrl.step = 1'b1;
            end
            ST_NORM:
            begin
                dig_ctrl.norm = norm_more;
            end
            ST_EMIT:
            begin
                emit          = slot_free;
                dig_ctrl.emit = slot_free && dig_sel;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        bit_cnt_next  = bit_cnt_reg;
        neg_next      = neg_reg;
        vzero_next    = vzero_reg;
        dl_eff_next   = dl_eff_reg;
        zl_next       = zl_reg;
        sign_on_next  = sign_on_reg;
        sign_chr_next = sign_chr_reg;
        plen_next     = plen_reg;
        uz_next       = uz_reg;
        left_next     = left_reg;
        lead_next     = lead_reg;
        pre_next      = pre_reg;
        zero_next     = zero_reg;
        dig_cnt_next  = dig_cnt_reg;
        trail_next    = trail_reg;
        rem_next      = rem_reg;
        case (state_reg)
            ST_IDLE:
            begin
                bit_cnt_next = 6'd0;
                neg_next     = neg_now;
                vzero_next   = (vmasked == '0);
            end
            ST_CONV:
            begin
                bit_cnt_next = bit_cnt_reg + 6'd1;
            end
            ST_PLAN1:
            begin
                dl_eff_next  = DLW'(dle_w);
                zl_next      = CW'(zl_w + WW'(oct_fix));
                sign_on_next = (conv_eff == CONV_SDEC)
                               && (neg_reg || flags_reg[FLAG_PLUS] || flags_reg[FLAG_SPACE]);
                if (neg_reg)
                begin
                    sign_chr_next = CH_MINUS;
                end
                else if (flags_reg[FLAG_PLUS])
                begin
                    sign_chr_next = CH_PLUS;
                end
                else
                begin
                    sign_chr_next = CH_SPACE;
                end
                plen_next = flags_reg[FLAG_ALT] && (base == BASE_HEX) && !vzero_reg;
                left_next = flags_reg[FLAG_LEFT];
                uz_next   = flags_reg[FLAG_ZPAD] && !has_prec && !flags_reg[FLAG_LEFT];
            end
            ST_PLAN2:
            begin
                lead_next    = (!left_reg && !uz_reg) ? CW'(pad_w) : '0;
                pre_next     = plen_reg ? 2'd2 : 2'd0;
                zero_next    = CW'(WW'(zl_reg) + (uz_reg ? pad_w : '0));
                dig_cnt_next = dl_eff_reg;
                trail_next   = left_reg ? CW'(pad_w) : '0;
                rem_next     = CW'(total_w);
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    rem_next = rem_reg - 1'b1;
                    if (lead_reg != '0)
                    begin
                        lead_next = lead_reg - 1'b1;
                    end
                    else if (sign_on_reg)
                    begin
                        sign_on_next = 1'b0;
                    end
                    else if (pre_reg != 2'd0)
                    begin
                        pre_next = pre_reg - 2'd1;
                    end
                    else if (zero_reg != '0)
                    begin
                        zero_next = zero_reg - 1'b1;
                    end
                    else if (dig_cnt_reg != '0)
                    begin
                        dig_cnt_next = dig_cnt_reg - 1'b1;
                    end
                    else if (trail_reg != '0)
                    begin
                        trail_next = trail_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                rem_next = rem_reg;
            end
        endcase
    end

    // Sequencer, configuration registers and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            conv_reg   <= CONV_SDEC;
            size_reg   <= SIZE_INT;
            width_reg  <= 6'd0;
            prec_reg   <= 7'h7F;
            flags_reg  <= 5'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_CONVERSION: conv_reg  <= cfg.data[2:0];
                    REG_SIZE_MODE:  size_reg  <= cfg.data[1:0];
                    REG_WIDTH:      width_reg <= cfg.data[5:0];
                    REG_PRECISION:  prec_reg  <= cfg.data;
                    REG_FLAGS:      flags_reg <= cfg.data[4:0];
                    default:        prec_reg  <= prec_reg;
                endcase
            end
            if (emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (text.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Plan, counters and output payload
    always_ff @(posedge clk)
    begin
        bit_cnt_reg  <= bit_cnt_next;
        neg_reg      <= neg_next;
        vzero_reg    <= vzero_next;
        dl_eff_reg   <= dl_eff_next;
        zl_reg       <= zl_next;
        sign_on_reg  <= sign_on_next;
        sign_chr_reg <= sign_chr_next;
        plen_reg     <= plen_next;
        uz_reg       <= uz_next;
        left_reg     <= left_next;
        lead_reg     <= lead_next;
        pre_reg      <= pre_next;
        zero_reg     <= zero_next;
        dig_cnt_reg  <= dig_cnt_next;
        trail_reg    <= trail_next;
        rem_reg      <= rem_next;
        if (emit)
        begin
            ochar_reg <= ch;
            olast_reg <= (rem_reg == CW'(1));
        end
    end

    assign cfg.ready      = 1'b1;
    assign text.valid     = ovalid_reg;
    assign text.out_char  = ochar_reg;
    assign text.last_char = olast_reg;

endmodule

// File: sv/pifu_checker.sv
// Port-level checks of the formatter and their binding to the top level.
module pifu_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          arg_valid,
    input logic                          arg_ready,
    input logic                          text_valid,
    input logic                          text_ready,
    input logic [pifu_pkg::CHAR_W-1:0]   out_char,
    input logic                          last_char
);
    import pifu_pkg::*;

    // Hold a stalled character request
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> text_valid)
        else $error("text request dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> $stable(out_char) && $stable(last_char))
        else $error("text payload changed while stalled");

    // One argument at a time: busy right after taking one
    assert property (@(posedge clk) disable iff (!rst_n)
        arg_valid && arg_ready |=> !arg_ready)
        else $error("argument taken while a conversion runs");

    // While idle, only the final character of a field can still wait
    assert property (@(posedge clk) disable iff (!rst_n)
        arg_ready && text_valid |-> last_char)
        else $error("idle with an unfinished field pending");

endmodule

bind printf_integer_formatter_unit pifu_checker u_pifu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .arg_valid  (arg.valid),
    .arg_ready  (arg.ready),
    .text_valid (text.valid),
    .text_ready (text.ready),
    .out_char   (text.out_char),
    .last_char  (text.last_char)
);

// File: test/printf_integer_formatter_unit_test.sv
// Self-checking testbench of the printf integer formatter: directed fields, then random formats.
module printf_integer_formatter_unit_test;
    import pifu_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int FIELD_MAX     = 62;
    localparam int SETTLE_CYCLES = 150;
    localparam int LONG_HOLD     = 600;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 33;
    localparam int MAX_PRINTED   = 40;

    // Codes that the package leaves unnamed
    localparam logic [1:0] SIZE_LONG    = 2'd2;
    localparam logic [1:0] SIZE_WIDE    = 2'd3;
    localparam logic [2:0] CONV_UNUSED7 = 3'd7;
    localparam logic [6:0] NO_PREC      = 7'h7F;
    localparam logic [6:0] PREC_NEG_MIN = 7'h40;
    localparam logic [6:0] PREC_TOP     = 7'h3F;
    localparam logic [5:0] WIDTH_TOP    = 6'h3F;

    localparam logic [4:0] F_LEFT  = 5'd1 << FLAG_LEFT;
    localparam logic [4:0] F_PLUS  = 5'd1 << FLAG_PLUS;
    localparam logic [4:0] F_SPACE = 5'd1 << FLAG_SPACE;
    localparam logic [4:0] F_ALT   = 5'd1 << FLAG_ALT;
    localparam logic [4:0] F_ZPAD  = 5'd1 << FLAG_ZPAD;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_beat_t;

    logic clk;
    logic rst_n;

    pifu_arg_if  arg_ch ();
    pifu_text_if text_ch ();
    pifu_cfg_if  cfg_ch ();

    printf_integer_formatter_unit #(
        .MAX_FIELD_CHARS(FIELD_MAX)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .arg   (arg_ch),
        .text  (text_ch),
        .cfg   (cfg_ch)
    );

    // Format registers as the block should hold them
    logic [2:0] fmt_conv;
    logic [1:0] fmt_size;
    logic [5:0] fmt_width;
    logic [6:0] fmt_prec;
    logic [4:0] fmt_flags;

    logic [VALUE_W-1:0] pending_values[$];
    text_beat_t         expected_chars[$];
    int                 values_queued;
    int                 values_taken;
    int                 chars_seen;
    int                 mismatches;
    int                 send_gap;
    int                 recv_gap;
    bit                 sender_idles;
    bit                 receiver_idles;
    bit                 long_hold;
    bit                 hold_arm;
    int                 hold_mark;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
        begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endtask

    // Build the expected field for one argument and queue its characters
    function automatic void format_field(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mask;
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic [CHAR_W-1:0]  digs[0:71];
        logic [CHAR_W-1:0]  sign_ch;
        logic [CHAR_W-1:0]  field[$];
        logic [2:0]         conv;
        int                 bits;
        int                 d;
        int                 dl;
        int                 zl;
        int                 prec;
        int                 width;
        int                 content;
        int                 pad;
        int                 plen;
        int                 i;
        bit                 upper;
        bit                 left;
        bit                 zero_fill;
        text_beat_t         beat;

        conv  = (fmt_conv > CONV_XUP) ? CONV_UDEC : fmt_conv;
        upper = (conv == CONV_XUP);
        if (fmt_size == SIZE_SHORT)
        begin
            bits = 16;
            mask = 64'hFFFF;
        end
        else if (fmt_size == SIZE_INT)
        begin
            bits = 32;
            mask = 64'hFFFF_FFFF;
        end
        else
        begin
            bits = 64;
            mask = '1;
        end
        v       = raw & mask;
        mag     = v;
        sign_ch = '0;

        // Sign only for signed decimal; plus wins over space
        if (conv == CONV_SDEC)
        begin
            if (v[bits-1])
            begin
                sign_ch = CH_MINUS;
                mag     = (~v + 64'd1) & mask;
            end
            else if (fmt_flags[FLAG_PLUS])
            begin
                sign_ch = CH_PLUS;
            end
            else if (fmt_flags[FLAG_SPACE])
            begin
                sign_ch = CH_SPACE;
            end
        end

        // Extract digits, least significant first
        radix = (conv == CONV_OCT) ? 64'd8 : ((conv >= CONV_XLO) ? 64'd16 : 64'd10);
        dl = 0;
        do
        begin
            d = int'(mag % radix);
            if (d < 10)
            begin
                digs[dl] = CH_ZERO + CHAR_W'(d);
            end
            else
            begin
                digs[dl] = (upper ? CH_A_UP : CH_A_LO) + CHAR_W'(d - 10);
            end
            dl++;
            mag = mag / radix;
        end
        while (mag != 0);

        prec = int'($signed(fmt_prec));
        if (prec < 0)
        begin
            prec = -1;
        end
        if (prec > FIELD_MAX - 2)
        begin
            prec = FIELD_MAX - 2;
        end

        // Zero value with zero precision prints no digits
        if (prec == 0 && dl == 1 && digs[0] == CH_ZERO)
        begin
            dl = 0;
        end
        zl   = (prec > dl) ? prec - dl : 0;
        plen = 0;
        if (fmt_flags[FLAG_ALT] && conv == CONV_OCT)
        begin
            if (!(zl > 0 || (dl > 0 && digs[dl-1] == CH_ZERO)))
            begin
                zl++;
            end
        end
        else if (fmt_flags[FLAG_ALT] && conv >= CONV_XLO && v != 0)
        begin
            plen = 2;
        end

        left      = fmt_flags[FLAG_LEFT];
        zero_fill = fmt_flags[FLAG_ZPAD] && prec < 0 && !left;
        width     = (int'(fmt_width) > FIELD_MAX) ? FIELD_MAX : int'(fmt_width);
        content   = ((sign_ch != '0) ? 1 : 0) + plen + zl + dl;
        pad       = (width > content) ? width - content : 0;

        // Assemble the field in print order
        if (!left && !zero_fill)
        begin
            for (i = 0; i < pad; i++) field.push_back(CH_SPACE);
        end
        if (sign_ch != '0)
        begin
            field.push_back(sign_ch);
        end
        if (plen != 0)
        begin
            field.push_back(CH_ZERO);
            field.push_back(upper ? CH_X_UP : CH_X_LO);
        end
        if (zero_fill)
        begin
            for (i = 0; i < pad; i++) field.push_back(CH_ZERO);
        end
        for (i = 0; i < zl; i++) field.push_back(CH_ZERO);
        for (i = dl - 1; i >= 0; i--) field.push_back(digs[i]);
        if (left)
        begin
            for (i = 0; i < pad; i++) field.push_back(CH_SPACE);
        end

        for (i = 0; i < field.size(); i++)
        begin
            beat.ch   = field[i];
            beat.last = (i == field.size() - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Reset once and drive every input to a known value from time zero
    initial
    begin
        rst_n              = 1'b0;
        arg_ch.valid       = 1'b0;
        arg_ch.value_bits  = '0;
        text_ch.ready      = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Argument driver: take the next pending value, idle in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arg_ch.valid      <= 1'b0;
            arg_ch.value_bits <= '0;
            send_gap = 0;
        end
        else
        begin
            if (arg_ch.valid && arg_ch.ready)
            begin
                format_field(arg_ch.value_bits);
                values_taken++;
            end
            if (!arg_ch.valid || arg_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    arg_ch.valid <= 1'b0;
                end
                else if (pending_values.size() > 0)
                begin
                    arg_ch.valid      <= 1'b1;
                    arg_ch.value_bits <= pending_values.pop_front();
                    if (sender_idles && $urandom_range(0, 5) == 0)
                    begin
                        send_gap = $urandom_range(1, 10);
                    end
                end
                else
                begin
                    arg_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Text monitor: check each character against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        text_beat_t exp_beat;
        if (!rst_n)
        begin
            text_ch.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                chars_seen++;
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("char %0d: unexpected 0x%02h last %0b",
                        chars_seen, text_ch.out_char, text_ch.last_char));
                end
                else
                begin
                    exp_beat = expected_chars.pop_front();
                    if (text_ch.out_char !== exp_beat.ch)
                    begin
                        report_mismatch($sformatf("char %0d: out_char 0x%02h, expected 0x%02h",
                            chars_seen, text_ch.out_char, exp_beat.ch));
                    end
                    if (text_ch.last_char !== exp_beat.last)
                    begin
                        report_mismatch($sformatf("char %0d: last_char %0b, expected %0b",
                            chars_seen, text_ch.last_char, exp_beat.last));
                    end
                end
            end
            if (long_hold)
            begin
                text_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                text_ch.ready <= 1'b0;
            end
            else
            begin
                text_ch.ready <= 1'b1;
                if (receiver_idles && $urandom_range(0, 7) == 0)
                begin
                    recv_gap = $urandom_range(1, 10);
                end
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering arguments
    initial
    begin
        long_hold = 1'b0;
        wait (hold_arm && values_taken >= hold_mark);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Safety limit
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("printf_integer_formatter_unit test failed");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Write all five format registers back to back, then drop valid
    task automatic set_format(input logic [2:0] conv, input logic [1:0] size,
                              input logic [5:0] width, input logic [6:0] prec,
                              input logic [4:0] flags);
        write_reg(REG_CONVERSION, {4'd0, conv});
        write_reg(REG_SIZE_MODE, {5'd0, size});
        write_reg(REG_WIDTH, {1'b0, width});
        write_reg(REG_PRECISION, prec);
        write_reg(REG_FLAGS, {2'd0, flags});
        cfg_ch.valid <= 1'b0;
        fmt_conv  = conv;
        fmt_size  = size;
        fmt_width = width;
        fmt_prec  = prec;
        fmt_flags = flags;
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] v);
        pending_values.push_back(v);
        values_queued++;
    endtask

    // Wait until every argument is taken and every character is back, then let the block go idle
    task automatic drain();
        do @(negedge clk); while (values_taken != values_queued || expected_chars.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_format();
        logic [2:0] conv;
        logic [5:0] width;
        logic [6:0] prec;
        conv  = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
        width = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(0, 12)) : 6'($urandom_range(0, 63));
        case ($urandom_range(0, 3))
            0: prec = NO_PREC;
            1: prec = 7'($urandom_range(1, 6));
            2: prec = 7'($urandom_range(0, 127));
            default: prec = 7'd0;
        endcase
        set_format(conv, 2'($urandom_range(0, 3)), width, prec, 5'($urandom_range(0, 31)));
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 20));
            2: v = {$urandom, $urandom} | 64'hFFFF_FFFF_FFFF_8000;
            3: v = 64'd1 << $urandom_range(0, 63);
            4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: v = {$urandom, $urandom} & 64'hFFFF_FFFF_0000_FFFF;
        endcase
        return v;
    endfunction

    // Stimulus: reset format first, then directed formats, then random phases
    initial
    begin
        int ph;
        int k;
        fmt_conv       = CONV_SDEC;
        fmt_size       = SIZE_INT;
        fmt_width      = '0;
        fmt_prec       = NO_PREC;
        fmt_flags      = '0;
        values_queued  = 0;
        values_taken   = 0;
        chars_seen     = 0;
        mismatches     = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        hold_arm       = 1'b0;
        hold_mark      = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Reset format: plain signed int
        send_value(64'd0);
        send_value(64'hFFFF_FFFF_8000_0000);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        // Zero precision: empty field, then one digit
        set_format(CONV_SDEC, SIZE_INT, 6'd0, 7'd0, 5'd0);
        send_value(64'd0);
        send_value(64'hDEAD_BEEF_0000_0007);
        drain();

        // Alternate octal, including the empty-digit case
        set_format(CONV_OCT, SIZE_LONG, 6'd0, 7'd0, F_ALT);
        send_value(64'd0);
        send_value(64'd8);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        // Alternate upper hex with zero pad; no prefix for zero
        set_format(CONV_XUP, SIZE_LONG, 6'd20, NO_PREC, F_ALT | F_ZPAD);
        send_value(64'd0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'h8000_0000_0000_0000);
        drain();

        // Every flag, saturated width and precision, short size
        set_format(CONV_XLO, SIZE_SHORT, WIDTH_TOP, PREC_TOP,
                   F_LEFT | F_PLUS | F_SPACE | F_ALT | F_ZPAD);
        send_value(64'h1234_5678_9ABC_DEF0);
        drain();

        // Out-of-range conversion and size codes act as unsigned long
        set_format(CONV_UNUSED7, SIZE_WIDE, 6'd0, NO_PREC, F_PLUS | F_SPACE);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        // Zero pad ignored under a precision; plus wins over space
        set_format(CONV_SDEC, SIZE_SHORT, 6'd10, 7'd3, F_PLUS | F_SPACE | F_ZPAD);
        send_value(64'h7FFF);
        send_value(64'h8000);
        send_value(64'd5);
        drain();

        // Negative precision means none, so zero pad applies after the sign
        set_format(CONV_SDEC, SIZE_INT, 6'd12, PREC_NEG_MIN, F_SPACE | F_ZPAD);
        send_value(64'd42);
        send_value(64'hFFFF_FFD6);
        drain();

        // Most negative long
        set_format(CONV_SDEC, SIZE_LONG, 6'd0, NO_PREC, 5'd0);
        send_value(64'h8000_0000_0000_0000);
        drain();

        // Random formats and values
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            sender_idles   = (ph < NUM_PHASES - 2) && (ph != 5);
            receiver_idles = sender_idles;
            random_format();
            if (ph == 2)
            begin
                hold_mark = values_taken + 5;
                hold_arm  = 1'b1;
            end
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                send_value(random_value());
            end
            drain();
        end

        if (mismatches == 0)
        begin
            $display("printf_integer_formatter_unit test passed");
        end
        else
        begin
            $display("printf_integer_formatter_unit test failed");
        end
        $finish;
    end

endmodule
